// File: hw/rtl/bounded_value_stack_assert.svh
// Assertion macros for the bounded value stack RTL.
// Used by bounded_value_stack.sv; define ASSERT_OFF to compile them away.
`ifndef BOUNDED_VALUE_STACK_ASSERT_SVH
`define BOUNDED_VALUE_STACK_ASSERT_SVH
`ifndef ASSERT_OFF
`define BVS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_value_stack: check failed");
`define BVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded_value_stack: check failed");
`else
`define BVS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define BVS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/bvs_pkg.sv
// Shared types and constants for the bounded value stack.
// No dependencies; used by bounded_value_stack.sv and tb_top.sv.
package bvs_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int WORD_WIDTH_DEFAULT = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH        = 3'd0,
    KIND_PUSH_NEW    = 3'd1,
    KIND_POP         = 3'd2,
    KIND_READ_TOP    = 3'd3,
    KIND_READ_BOTTOM = 3'd4,
    KIND_TRUNCATE    = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISSING = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_DUP     = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

// File: hw/rtl/bounded_value_stack.sv
// Bounded LIFO stack of words with a kept count, entries held in one RAM.
// Depends on bvs_pkg, bvs_ram and bounded_value_stack_assert.svh.
//
// Usage:
//   Command channel: an operation (kind, value, index) is taken at a rising
//   edge with start high and busy low. Kinds: push, push unless equal to
//   top, pop, read from top, read from bottom, truncate.
//   Result channel: done is high for exactly one cycle with data, status
//   and count; the receiver cannot stall, so every result must be taken then.
//   Config: cfg_we writes cfg_data into the default value register at once;
//   write it only while no operation is in flight.
//   Timing: at the accepting edge the RAM read and the operation are
//   registered and the FSM enters its execute state, in which the
//   modify/write-back is done; data, status, count and done are registered
//   at the edge that ends that state.
//   Operations do not overlap: busy is high during write-back, and start
//   may be held high in the cycle done is shown.
//   Reset (rst, synchronous): the kept count and default value clear to zero, no
//   result is pending. RAM contents are not cleared; no entry below the
//   count is ever unwritten.
module bounded_value_stack #(
  parameter int DEPTH      = bvs_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = bvs_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [bvs_pkg::KIND_W-1:0]   kind,
  input  logic [bvs_pkg::VALUE_W-1:0]  value,
  input  logic [bvs_pkg::INDEX_W-1:0]  index,
  input  logic                         cfg_we,
  input  logic [bvs_pkg::DATA_W-1:0]   cfg_data,
  output logic                         done,
  output logic [bvs_pkg::DATA_W-1:0]   data,
  output logic [bvs_pkg::STATUS_W-1:0] status,
  output logic [bvs_pkg::COUNT_W-1:0]  count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int MW   = (CNTW > bvs_pkg::INDEX_W) ? CNTW : bvs_pkg::INDEX_W;
  localparam int CW   = (WORD_WIDTH > bvs_pkg::DATA_W) ? WORD_WIDTH : bvs_pkg::DATA_W;

  bvs_pkg::state_t state, state_next;

  logic [CNTW-1:0]            fill, fill_next;
  logic [bvs_pkg::DATA_W-1:0] default_value;

  bvs_pkg::kind_t             op_kind;
  logic [WORD_WIDTH-1:0]      op_word;
  logic [CNTW-1:0]            op_idx;
  logic                       op_hit;

  logic [MW-1:0]              fill_mw, idx_mw, top_addr_mw, depth_addr_mw;
  logic [AW-1:0]              ram_raddr;
  logic                       hit_in;
  logic                       accept;

  logic                       ram_we;
  logic [WORD_WIDTH-1:0]      ram_rdata;

  logic [CW-1:0]              rd_ext, word_ext, top_ext;
  logic [bvs_pkg::DATA_W-1:0] data_next;
  bvs_pkg::status_t           status_next;

  assign busy   = (state == bvs_pkg::ST_EXEC);
  assign accept = start && !busy;

  // read address and presence, computed on the accepting edge
  assign fill_mw       = MW'(fill);
  assign idx_mw        = MW'(index);
  assign top_addr_mw   = MW'(fill_mw - MW'(1));
  assign depth_addr_mw = MW'(fill_mw - idx_mw - MW'(1));

  always_comb begin
    ram_raddr = top_addr_mw[AW-1:0];
    hit_in    = (idx_mw < fill_mw);
    case (bvs_pkg::kind_t'(kind))
      bvs_pkg::KIND_PUSH_NEW, bvs_pkg::KIND_POP: begin
        ram_raddr = top_addr_mw[AW-1:0];
        hit_in    = (fill != '0);
      end
      bvs_pkg::KIND_READ_TOP: begin
        ram_raddr = depth_addr_mw[AW-1:0];
      end
      bvs_pkg::KIND_READ_BOTTOM: begin
        ram_raddr = idx_mw[AW-1:0];
      end
      default: begin
        ram_raddr = top_addr_mw[AW-1:0];
      end
    endcase
  end

  bvs_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata (op_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ext   = CW'(ram_rdata);
  assign word_ext = CW'(op_word);
  assign top_ext  = op_hit ? rd_ext : CW'(default_value);

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    ram_we      = 1'b0;
    data_next   = '0;
    status_next = bvs_pkg::STATUS_OK;
    case (state)
      bvs_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = bvs_pkg::ST_EXEC;
        end
      end
      bvs_pkg::ST_EXEC: begin
        state_next = bvs_pkg::ST_IDLE;
        case (op_kind)
          bvs_pkg::KIND_PUSH, bvs_pkg::KIND_PUSH_NEW: begin
            if (op_kind == bvs_pkg::KIND_PUSH_NEW && word_ext == top_ext) begin
              status_next = bvs_pkg::STATUS_DUP;
            end else if (fill == CNTW'(DEPTH)) begin
              status_next = bvs_pkg::STATUS_FULL;
            end else begin
              ram_we    = 1'b1;
              fill_next = CNTW'(fill + CNTW'(1));
            end
          end
          bvs_pkg::KIND_POP: begin
            if (!op_hit) begin
              data_next   = default_value;
              status_next = bvs_pkg::STATUS_MISSING;
            end else begin
              data_next = rd_ext[bvs_pkg::DATA_W-1:0];
              fill_next = CNTW'(fill - CNTW'(1));
            end
          end
          bvs_pkg::KIND_READ_TOP: begin
            if (!op_hit) begin
              data_next   = default_value;
              status_next = bvs_pkg::STATUS_MISSING;
            end else begin
              data_next = rd_ext[bvs_pkg::DATA_W-1:0];
            end
          end
          bvs_pkg::KIND_READ_BOTTOM: begin
            if (!op_hit) begin
              status_next = bvs_pkg::STATUS_MISSING;
            end else begin
              data_next = rd_ext[bvs_pkg::DATA_W-1:0];
            end
          end
          bvs_pkg::KIND_TRUNCATE: begin
            if (op_hit) begin
              fill_next = op_idx;
            end
          end
          default: begin
            fill_next = fill;
          end
        endcase
      end
      default: begin
        state_next = bvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      done          <= 1'b0;
      default_value <= '0;
    end else begin
      fill <= fill_next;
      done <= (state == bvs_pkg::ST_EXEC);
      if (cfg_we) begin
        default_value <= cfg_data;
      end
    end
  end

  // hold the operation across the RAM read
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind <= bvs_pkg::kind_t'(kind);
      op_word <= WORD_WIDTH'(value);
      op_idx  <= CNTW'(index);
      op_hit  <= hit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bvs_pkg::ST_EXEC) begin
      data   <= data_next;
      status <= status_next;
      count  <= bvs_pkg::COUNT_W'(fill_next);
    end
  end

`include "bounded_value_stack_assert.svh"

  `BVS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `BVS_ASSERT_NEXT(a_exec_done, clk, rst, state == bvs_pkg::ST_EXEC, done && !busy)
  `BVS_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= CNTW'(DEPTH))
  `BVS_ASSERT_NEXT(a_push_grows, clk, rst, ram_we, fill == CNTW'($past(fill) + CNTW'(1)))
  `BVS_ASSERT_IMPL(a_write_in_exec, clk, rst, ram_we, state == bvs_pkg::ST_EXEC)

endmodule

// File: hw/rtl/bvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced by bounded_value_stack.sv.
module bvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for bounded_value_stack: drives operations with random gaps,
// predicts each result from a local stack image and compares every done beat.
// Depends on bvs_pkg and the bounded_value_stack RTL.
`timescale 1ns / 1ps

module tb_top;
  import bvs_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [INDEX_W-1:0] INDEX_MAX = 7'(STACK_DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t st;
    logic [COUNT_W-1:0] cnt;
  } op_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [KIND_W-1:0] kind;
  logic [VALUE_W-1:0] value;
  logic [INDEX_W-1:0] index;
  logic cfg_we;
  logic [DATA_W-1:0] cfg_data;
  logic done;
  logic [DATA_W-1:0] data;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] count;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int fill_level;
  logic [DATA_W-1:0] default_word;
  op_result_t pending_results [$];
  int mismatch_count;
  int idle_cycles;
  bit burst_mode;

  bounded_value_stack i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .kind    (kind),
    .value   (value),
    .index   (index),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .done    (done),
    .data    (data),
    .status  (status),
    .count   (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_t push_word(input logic [VALUE_W-1:0] v);
    if (fill_level >= STACK_DEPTH) begin
      return STATUS_FULL;
    end
    stack_mem[fill_level] = v;
    fill_level++;
    return STATUS_OK;
  endfunction

  function automatic logic [DATA_W-1:0] top_word();
    return (fill_level != 0) ? stack_mem[fill_level - 1] : default_word;
  endfunction

  function automatic op_result_t predict_op(input logic [KIND_W-1:0] op,
                                            input logic [VALUE_W-1:0] v,
                                            input logic [INDEX_W-1:0] idx);
    op_result_t r;
    r.data = '0;
    r.st = STATUS_OK;
    case (op)
      KIND_PUSH: begin
        r.st = push_word(v);
      end
      KIND_PUSH_NEW: begin
        if (v == top_word()) r.st = STATUS_DUP;
        else r.st = push_word(v);
      end
      KIND_POP: begin
        if (fill_level == 0) begin
          r.data = default_word;
          r.st = STATUS_MISSING;
        end else begin
          fill_level--;
          r.data = stack_mem[fill_level];
        end
      end
      KIND_READ_TOP: begin
        if (int'(idx) >= fill_level) begin
          r.data = default_word;
          r.st = STATUS_MISSING;
        end else begin
          r.data = stack_mem[fill_level - 1 - int'(idx)];
        end
      end
      KIND_READ_BOTTOM: begin
        if (int'(idx) >= fill_level) r.st = STATUS_MISSING;
        else r.data = stack_mem[idx];
      end
      KIND_TRUNCATE: begin
        if (int'(idx) < fill_level) fill_level = int'(idx);
      end
      default: begin
      end
    endcase
    r.cnt = COUNT_W'(fill_level);
    return r;
  endfunction

  function automatic void note_error(input string msg);
    if (mismatch_count < 10) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endfunction

  // Check each done beat against the oldest prediction.
  always @(posedge clk) begin
    op_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected beat: data %h status %0d count %0d",
                             data, status, count));
      end else begin
        want = pending_results.pop_front();
        if (data !== want.data)
          note_error($sformatf("data: expected %h got %h", want.data, data));
        if (status !== want.st)
          note_error($sformatf("status: expected %0d got %0d", want.st, status));
        if (count !== want.cnt)
          note_error($sformatf("count: expected %0d got %0d", want.cnt, count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] v,
                         input logic [INDEX_W-1:0] idx);
    int gap;
    gap = burst_mode ? 0 : int'($urandom_range(0, 8));
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    kind <= op;
    value <= v;
    index <= idx;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_op(op, v, idx));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_default_value(input logic [DATA_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= $urandom;
    default_word = v;
  endtask

  task automatic test_reset_default();
    send_op(KIND_POP, '0, '0);
    send_op(KIND_PUSH_NEW, '0, '0);
    send_op(KIND_READ_TOP, '1, '0);
  endtask

  task automatic test_edge_cases();
    set_default_value('1);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_READ_TOP, '0, '0);
    send_op(KIND_READ_BOTTOM, '0, '0);
    send_op(KIND_PUSH_NEW, '1, '0);
    send_op(KIND_PUSH_NEW, '0, '0);
    send_op(KIND_PUSH, '0, '0);
    send_op(KIND_PUSH_NEW, '0, '0);
    send_op(KIND_PUSH, '1, '0);
    send_op(KIND_READ_TOP, '0, 7'd0);
    send_op(KIND_READ_TOP, '0, 7'd2);
    send_op(KIND_READ_TOP, '0, 7'd3);
    send_op(KIND_READ_TOP, '0, INDEX_MAX);
    send_op(KIND_READ_BOTTOM, '0, 7'd2);
    send_op(KIND_READ_BOTTOM, '0, 7'd3);
    send_op(KIND_READ_BOTTOM, '0, INDEX_MAX);
    send_op(KIND_TRUNCATE, '0, INDEX_MAX);
    send_op(KIND_TRUNCATE, '0, 7'd3);
    send_op(KIND_SPARE_LO, '1, INDEX_MAX);
    send_op(KIND_SPARE_HI, '1, INDEX_MAX);
    send_op(KIND_TRUNCATE, '0, 7'd1);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_POP, '0, '0);
  endtask

  task automatic test_full_stack();
    logic [VALUE_W-1:0] w;
    set_default_value(32'h8000_0000);
    while (fill_level < STACK_DEPTH) send_op(KIND_PUSH, $urandom, '0);
    w = top_word();
    send_op(KIND_PUSH, $urandom, '0);
    send_op(KIND_PUSH_NEW, w, '0);
    send_op(KIND_PUSH_NEW, ~w, '0);
    send_op(KIND_READ_BOTTOM, '0, INDEX_MAX - 7'd1);
    send_op(KIND_READ_BOTTOM, '0, INDEX_MAX);
    send_op(KIND_READ_TOP, '0, INDEX_MAX - 7'd1);
    send_op(KIND_READ_TOP, '0, INDEX_MAX);
    send_op(KIND_POP, '0, '0);
    send_op(KIND_TRUNCATE, '0, INDEX_MAX);
    send_op(KIND_TRUNCATE, '0, '0);
  endtask

  task automatic test_random_ops();
    int push_pct [6] = '{70, 30, 55, 85, 20, 50};
    logic [DATA_W-1:0] dflt [6];
    logic [KIND_W-1:0] op;
    logic [VALUE_W-1:0] v;
    int near;
    int roll;
    dflt = '{32'h0, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, 32'h1};
    for (int ph = 0; ph < 6; ph++) begin
      set_default_value(dflt[ph]);
      for (int n = 0; n < 250; n++) begin
        if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        roll = int'($urandom_range(0, 99));
        if (roll < push_pct[ph]) begin
          op = $urandom_range(0, 1) ? KIND_PUSH : KIND_PUSH_NEW;
        end else begin
          roll = int'($urandom_range(0, 99));
          if (roll < 35) op = KIND_POP;
          else if (roll < 60) op = KIND_READ_TOP;
          else if (roll < 85) op = KIND_READ_BOTTOM;
          else if (roll < 95) op = KIND_TRUNCATE;
          else op = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
        end
        case ($urandom_range(0, 9))
          0, 1: v = top_word();
          2: v = default_word;
          3: v = $urandom_range(0, 1) ? '1 : '0;
          default: v = $urandom;
        endcase
        if ($urandom_range(0, 3) == 0) begin
          near = int'($urandom_range(0, STACK_DEPTH));
        end else begin
          near = fill_level + int'($urandom_range(0, 4)) - 2;
          if (near < 0) near = 0;
          if (near > STACK_DEPTH) near = STACK_DEPTH;
        end
        send_op(op, v, INDEX_W'(near));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = '0;
    value = '0;
    index = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fill_level = 0;
    default_word = '0;
    mismatch_count = 0;
    burst_mode = 1'b0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_edge_cases();
    test_full_stack();
    test_random_ops();

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bvs_pkg.sv
hw/rtl/bvs_ram.sv
hw/rtl/bounded_value_stack.sv
tb/tb_top.sv
